/* rtl/bckl_pkg.sv */
package bckl_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int KEY_WIDTH_DEF = 32;

	localparam int CMD_W    = 3;
	localparam int KEY_W    = 32;
	localparam int POS_W    = 4;
	localparam int STATUS_W = 2;
	localparam int CAP_W    = 5;
	localparam int COUNT_W  = 5;

	localparam logic [CAP_W-1:0] CAP_RESET = 5'd10;

	localparam logic [CMD_W-1:0] CMD_APPEND     = 3'd0;
	localparam logic [CMD_W-1:0] CMD_REMOVE_KEY = 3'd1;
	localparam logic [CMD_W-1:0] CMD_REMOVE_AT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_CONTAINS   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_READ_AT    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] ST_MISS = 2'd2;

	typedef struct packed {
		logic [CMD_W-1:0] command;
		logic [KEY_W-1:0] key;
		logic [POS_W-1:0] position;
	} cmd_beat_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic                found;
		logic [KEY_W-1:0]    read_key;
		logic [COUNT_W-1:0]  entry_count;
	} res_beat_t;

	typedef struct packed {
		logic busy;
		logic done;
	} seq_ctl_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_READ,
		S_SCAN,
		S_SHIFT,
		S_DONE
	} state_t;

endpackage

/* rtl/bounded_compacting_key_list.sv */
// Bounded compacting key list.
// Command channel: cmd_valid / cmd_stall / cmd. A beat is taken when cmd_valid is
// high and cmd_stall low; cmd_stall stays high while a command is in progress.
// Result channel: res_valid / res_stall / res, one result beat per command, held
// in an output register that is not cleared until the receiver takes it.
// Configuration: cfg_we writes cfg_wdata into capacity_limit (cap_q); the user must
// write it while idle only, the block itself does not enforce this.
// Steps by command: append, unused codes and out-of-range positions go from EXEC
// straight to DONE; read at position goes through READ; contains and remove key
// scan the list (SCAN), and both removals close the gap by shifting later entries
// one slot down (SHIFT). The block returns to idle after each command completes
// and takes the next command beat only there.
// Scans and shifts walk the single key RAM one entry per cycle through its one
// read and one write port.
// The next command is taken while a result still waits; it completes into the
// output register once that register is free, so a stalled receiver holds the
// block at most one command ahead.
// Reset clears the count to zero and capacity_limit to 10; no RAM clear pass.
module bounded_compacting_key_list #(
	parameter int DEPTH     = bckl_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = bckl_pkg::KEY_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	output logic                       cmd_stall,
	input  bckl_pkg::cmd_beat_t        cmd,
	output logic                       res_valid,
	input  logic                       res_stall,
	output bckl_pkg::res_beat_t        res,
	input  logic                       cfg_we,
	input  logic [bckl_pkg::CAP_W-1:0] cfg_wdata
);

	import bckl_pkg::*;

	logic [CAP_W-1:0] cap_q;
	logic             res_valid_q;
	res_beat_t        res_q;
	res_beat_t        seq_res;
	seq_ctl_t         ctl;
	logic             out_free;

	assign out_free = !res_valid_q || !res_stall;

	bckl_seq #(
		.DEPTH    (DEPTH),
		.KEY_WIDTH(KEY_WIDTH)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cap      (cap_q),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.out_free (out_free),
		.ctl      (ctl),
		.result   (seq_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= CAP_RESET;
			res_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (ctl.done) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.done) begin
			res_q <= seq_res;
		end
	end

	assign cmd_stall = ctl.busy;
	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

/* rtl/bckl_ram.sv */
module bckl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/bckl_seq.sv */
module bckl_seq #(
	parameter int DEPTH     = bckl_pkg::DEPTH_DEF,
	parameter int KEY_WIDTH = bckl_pkg::KEY_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [bckl_pkg::CAP_W-1:0] cap,
	input  logic                     cmd_valid,
	input  bckl_pkg::cmd_beat_t      cmd,
	input  logic                     out_free,
	output bckl_pkg::seq_ctl_t       ctl,
	output bckl_pkg::res_beat_t      result
);

	import bckl_pkg::*;

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam int EW = (CW > CAP_W) ? CW : CAP_W;

	state_t state_q, state_d;

	logic [CMD_W-1:0]     cmd_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [POS_W-1:0]     pos_q;
	logic [CW-1:0]        count_q, count_d;
	logic [CW-1:0]        idx_q, idx_d;
	logic [AW-1:0]        idx_s1, idx_s1_d;
	logic                 pend_s1, pend_d;
	logic [STATUS_W-1:0]  status_q, status_d;
	logic                 found_q, found_d;
	logic [KEY_W-1:0]     rkey_q, rkey_d;
	logic                 load;

	logic                 ram_we;
	logic [AW-1:0]        ram_waddr, ram_raddr;
	logic [KEY_WIDTH-1:0] ram_wdata, ram_rdata;

	logic [63:0]          key_ext, rd_ext;
	logic [EW-1:0]        cnt_ext, cap_ext, pos_ext;
	logic                 idx_lt_cnt, hit, room, pos_ok;

	assign key_ext    = {32'd0, cmd.key};
	assign rd_ext     = 64'(ram_rdata);
	assign cnt_ext    = EW'(count_q);
	assign cap_ext    = EW'(cap);
	assign pos_ext    = EW'(pos_q);
	assign idx_lt_cnt = idx_q < count_q;
	assign hit        = pend_s1 && (ram_rdata == key_q);
	assign room       = (cnt_ext < cap_ext) && (cnt_ext < EW'(DEPTH));
	assign pos_ok     = pos_ext < cnt_ext;

	bckl_ram #(
		.WIDTH(KEY_WIDTH),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			pend_s1 <= 1'b0;
		end else begin
			count_q <= count_d;
			pend_s1 <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cmd_q <= cmd.command;
			key_q <= key_ext[KEY_WIDTH-1:0];
			pos_q <= cmd.position;
		end
		idx_q    <= idx_d;
		idx_s1   <= idx_s1_d;
		status_q <= status_d;
		found_q  <= found_d;
		rkey_q   <= rkey_d;
	end

	always_comb begin
		state_d   = state_q;
		count_d   = count_q;
		idx_d     = idx_q;
		idx_s1_d  = idx_s1;
		pend_d    = 1'b0;
		status_d  = status_q;
		found_d   = found_q;
		rkey_d    = rkey_q;
		load      = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = idx_s1 - 1'b1;
		ram_wdata = ram_rdata;
		ram_raddr = idx_q[AW-1:0];
		ctl.busy  = state_q != S_IDLE;
		ctl.done  = 1'b0;

		case (state_q)
			S_IDLE: begin
				if (cmd_valid) begin
					load     = 1'b1;
					status_d = ST_OK;
					found_d  = 1'b0;
					rkey_d   = '0;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				case (cmd_q)
					CMD_APPEND: begin
						if (room) begin
							ram_we    = 1'b1;
							ram_waddr = count_q[AW-1:0];
							ram_wdata = key_q;
							count_d   = count_q + 1'b1;
						end else begin
							status_d = ST_FULL;
						end
						state_d = S_DONE;
					end
					CMD_REMOVE_KEY, CMD_CONTAINS: begin
						idx_d   = '0;
						state_d = S_SCAN;
					end
					CMD_REMOVE_AT: begin
						if (pos_ok) begin
							idx_d   = CW'(pos_ext + 1'b1);
							state_d = S_SHIFT;
						end else begin
							status_d = ST_MISS;
							state_d  = S_DONE;
						end
					end
					CMD_READ_AT: begin
						if (pos_ok) begin
							ram_raddr = pos_ext[AW-1:0];
							state_d   = S_READ;
						end else begin
							status_d = ST_MISS;
							state_d  = S_DONE;
						end
					end
					default: begin
						state_d = S_DONE;
					end
				endcase
			end
			S_READ: begin
				rkey_d  = rd_ext[KEY_W-1:0];
				state_d = S_DONE;
			end
			S_SCAN: begin
				// read issued in the cycle before its compare
				if (hit) begin
					if (cmd_q == CMD_CONTAINS) begin
						found_d = 1'b1;
						state_d = S_DONE;
					end else begin
						idx_d   = CW'(idx_s1) + 1'b1;
						state_d = S_SHIFT;
					end
				end else if (idx_lt_cnt) begin
					pend_d   = 1'b1;
					idx_s1_d = idx_q[AW-1:0];
					idx_d    = idx_q + 1'b1;
				end else if (!pend_s1) begin
					if (cmd_q == CMD_REMOVE_KEY) begin
						status_d = ST_MISS;
					end
					state_d = S_DONE;
				end
			end
			S_SHIFT: begin
				// entry read last cycle lands one slot lower
				if (pend_s1) begin
					ram_we = 1'b1;
				end
				if (idx_lt_cnt) begin
					pend_d   = 1'b1;
					idx_s1_d = idx_q[AW-1:0];
					idx_d    = idx_q + 1'b1;
				end else if (!pend_s1) begin
					count_d = count_q - 1'b1;
					state_d = S_DONE;
				end
			end
			S_DONE: begin
				if (out_free) begin
					ctl.done = 1'b1;
					state_d  = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign result.status      = status_q;
	assign result.found       = found_q;
	assign result.read_key    = rkey_q;
	assign result.entry_count = cnt_ext[COUNT_W-1:0];

endmodule

/* rtl/bckl_chk.sv */
module bckl_chk (
	input logic                clk,
	input logic                arst_n,
	input logic                cmd_valid,
	input logic                cmd_stall,
	input logic                res_valid,
	input logic                res_stall,
	input bckl_pkg::res_beat_t res
);

	import bckl_pkg::*;

	// a taken command keeps the block busy for at least the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("command beat taken but block not busy");

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res))
		else $error("stalled result beat changed");

	a_err_clean: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.status != ST_OK |-> !res.found && res.read_key == '0)
		else $error("error status with found or read key set");

	a_res_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid) |-> $past(cmd_stall))
		else $error("result beat without a command in progress");

endmodule

bind bounded_compacting_key_list bckl_chk u_bckl_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_valid(cmd_valid),
	.cmd_stall(cmd_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.res      (res)
);

/* bench/key_list_checker.sv */
module key_list_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cmd_valid,
	input  logic                       cmd_stall,
	input  bckl_pkg::cmd_beat_t        cmd,
	input  logic                       res_valid,
	input  logic                       res_stall,
	input  bckl_pkg::res_beat_t        res,
	input  logic                       cfg_we,
	input  logic [bckl_pkg::CAP_W-1:0] cfg_wdata,
	output int                         mismatches,
	output int                         outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import bckl_pkg::*;

	localparam int LIST_DEPTH = DEPTH_DEF;
	localparam int LIST_AW    = $clog2(LIST_DEPTH);
	localparam int REPORT_MAX = 10;

	logic [KEY_W-1:0]   list_keys [LIST_DEPTH];
	logic [COUNT_W-1:0] list_count;
	logic [CAP_W-1:0]   capacity;
	res_beat_t          expected_results [$];
	res_beat_t          oldest;

	// close the gap left by the entry at idx
	function automatic void drop_entry(int idx);
		for (int i = idx; i + 1 < list_count; i++)
			list_keys[i] = list_keys[i + 1];
		list_count--;
	endfunction

	function automatic res_beat_t run_list_command(cmd_beat_t c);
		res_beat_t r;
		int        room;
		int        hit;
		r    = '0;
		room = (capacity > LIST_DEPTH) ? LIST_DEPTH : capacity;
		hit  = -1;
		for (int i = 0; i < list_count; i++) begin
			if (hit < 0 && list_keys[i] == c.key)
				hit = i;
		end
		case (c.command)
			CMD_APPEND: begin
				if (list_count < room) begin
					list_keys[list_count[LIST_AW-1:0]] = c.key;
					list_count++;
				end else begin
					r.status = ST_FULL;
				end
			end
			CMD_REMOVE_KEY: begin
				if (hit >= 0)
					drop_entry(hit);
				else
					r.status = ST_MISS;
			end
			CMD_REMOVE_AT: begin
				if (c.position < list_count)
					drop_entry(c.position);
				else
					r.status = ST_MISS;
			end
			CMD_CONTAINS: begin
				r.found = (hit >= 0);
			end
			CMD_READ_AT: begin
				if (c.position < list_count)
					r.read_key = list_keys[c.position];
				else
					r.status = ST_MISS;
			end
			default: begin
			end
		endcase
		r.entry_count = list_count;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			list_count = '0;
			capacity   = CAP_RESET;
			expected_results.delete();
			outstanding = 0;
		end else begin
			if (cfg_we)
				capacity = cfg_wdata;
			if (cmd_valid && !cmd_stall)
				expected_results.push_back(run_list_command(cmd));
			if (res_valid && !res_stall) begin
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("%0t: unexpected result beat status %0d found %0d key %h count %0d",
							$realtime, res.status, res.found, res.read_key, res.entry_count);
				end else begin
					oldest = expected_results.pop_front();
					if (res.status !== oldest.status || res.found !== oldest.found ||
						res.read_key !== oldest.read_key ||
						res.entry_count !== oldest.entry_count) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$write("%0t: result mismatch exp status %0d found %0d key %h count %0d,",
								$realtime, oldest.status, oldest.found, oldest.read_key,
								oldest.entry_count);
							$display(" got status %0d found %0d key %h count %0d",
								res.status, res.found, res.read_key, res.entry_count);
						end
					end
				end
			end
			outstanding = expected_results.size();
		end
	end

endmodule

/* bench/bounded_compacting_key_list_tb.sv */
module bounded_compacting_key_list_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import bckl_pkg::*;

	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd5;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;
	localparam int PHASE_ITEMS = 178;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int DRAIN_CYCLES = 50;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             cmd_valid = 1'b0;
	logic             cmd_stall;
	cmd_beat_t        cmd = '0;
	logic             res_valid;
	logic             res_stall = 1'b0;
	res_beat_t        res;
	logic             cfg_we = 1'b0;
	logic [CAP_W-1:0] cfg_wdata = '0;

	int mismatches;
	int outstanding;
	int cmds_accepted = 0;
	int cycle_count = 0;
	bit long_hold_done = 1'b0;

	logic [KEY_W-1:0] key_pool [8];
	int fixed_caps [6] = '{16, 3, 0, 31, 1, 7};
	int fixed_pct  [6] = '{65, 30, 40, 60, 35, 40};

	always #5 clk = ~clk;

	bounded_compacting_key_list DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	key_list_checker checker_i (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd_valid   (cmd_valid),
		.cmd_stall   (cmd_stall),
		.cmd         (cmd),
		.res_valid   (res_valid),
		.res_stall   (res_stall),
		.res         (res),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mismatches  (mismatches),
		.outstanding (outstanding)
	);

	function automatic cmd_beat_t make_cmd(logic [CMD_W-1:0] op, logic [KEY_W-1:0] k,
		logic [POS_W-1:0] p);
		cmd_beat_t c;
		c.command  = op;
		c.key      = k;
		c.position = p;
		return c;
	endfunction

	function automatic cmd_beat_t random_command(int append_pct);
		cmd_beat_t c;
		int        pick;
		c.key      = ($urandom_range(0, 3) == 0) ? $urandom()
			: key_pool[$urandom_range(0, 7)];
		c.position = ($urandom_range(0, 1) == 0) ? POS_W'($urandom_range(0, 15))
			: POS_W'($urandom_range(0, 3));
		if ($urandom_range(0, 99) < append_pct) begin
			c.command = CMD_APPEND;
		end else begin
			pick = $urandom_range(0, 19);
			if (pick < 5)
				c.command = CMD_REMOVE_KEY;
			else if (pick < 10)
				c.command = CMD_REMOVE_AT;
			else if (pick < 15)
				c.command = CMD_CONTAINS;
			else if (pick < 19)
				c.command = CMD_READ_AT;
			else
				c.command = CMD_W'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI));
		end
		return c;
	endfunction

	// called at a falling edge, returns at the falling edge after the beat
	task automatic send_command(input cmd_beat_t c);
		cmd       <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		cmds_accepted++;
		@(negedge clk);
	endtask

	task automatic wait_idle();
		cmd_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [CAP_W-1:0] v);
		cfg_wdata <= v;
		cfg_we    <= 1'b1;
		@(negedge clk);
		cfg_we    <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input int append_pct);
		int sent;
		int burst;
		sent = 0;
		while (sent < PHASE_ITEMS) begin
			burst = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 120)
				: $urandom_range(1, 24);
			for (int b = 0; b < burst && sent < PHASE_ITEMS; b++) begin
				send_command(random_command(append_pct));
				sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				cmd_valid <= 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
		end
	endtask

	// receiver stall pattern, with one long hold-off so the block backs up
	initial begin
		int mode;
		int len;
		@(posedge arst_n);
		forever begin
			if (!long_hold_done && cmds_accepted >= 400) begin
				@(negedge clk);
				res_stall <= 1'b1;
				repeat (300) @(negedge clk);
				long_hold_done = 1'b1;
			end
			mode = $urandom_range(0, 3);
			len  = $urandom_range(10, 80);
			repeat (len) begin
				@(negedge clk);
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 1) == 0);
					2: res_stall <= ($urandom_range(0, 3) != 0);
					default: res_stall <= ~res_stall;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("bounded_compacting_key_list verification failed");
			$finish;
		end
	end

	initial begin
		int cap;
		int pct;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < 8; i++)
			key_pool[i] = $urandom();

		// directed: capacity still at its reset value
		send_command(make_cmd(CMD_APPEND, '0, 4'd0));
		send_command(make_cmd(CMD_APPEND, '1, 4'd15));
		send_command(make_cmd(CMD_APPEND, 32'hA5A5_5A5A, 4'd0));
		send_command(make_cmd(CMD_CONTAINS, '1, 4'd0));
		send_command(make_cmd(CMD_CONTAINS, 32'h0000_1234, 4'd0));
		send_command(make_cmd(CMD_READ_AT, '0, 4'd0));
		send_command(make_cmd(CMD_READ_AT, '0, 4'd2));
		send_command(make_cmd(CMD_READ_AT, '0, 4'd3));
		send_command(make_cmd(CMD_READ_AT, '1, 4'd15));
		send_command(make_cmd(CMD_REMOVE_KEY, 32'h0000_1234, 4'd0));
		send_command(make_cmd(CMD_REMOVE_KEY, '1, 4'd0));
		send_command(make_cmd(CMD_REMOVE_AT, '0, 4'd15));
		send_command(make_cmd(CMD_REMOVE_AT, '0, 4'd0));
		send_command(make_cmd(CMD_UNUSED_LO, '1, 4'd15));
		send_command(make_cmd(CMD_UNUSED_HI, '1, 4'd15));
		for (int i = 0; i < 9; i++)
			send_command(make_cmd(CMD_APPEND, key_pool[i % 8], 4'd0));
		send_command(make_cmd(CMD_APPEND, $urandom(), 4'd0));

		for (int p = 0; p < 10; p++) begin
			if (p < 6) begin
				cap = fixed_caps[p];
				pct = fixed_pct[p];
			end else begin
				cap = $urandom_range(0, 16);
				pct = $urandom_range(25, 55);
			end
			wait_idle();
			write_capacity(CAP_W'(cap));
			run_phase(pct);
		end

		cmd_valid <= 1'b0;
		@(negedge clk);
		while (outstanding != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (mismatches == 0 && outstanding == 0)
			$display("bounded_compacting_key_list verification clean");
		else
			$display("bounded_compacting_key_list verification failed");
		$finish;
	end

endmodule
